/* rtl/positional_list_engine_macros.svh */
// Assertion macros for the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define PLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional list engine check failed");

// Check that a condition implies another in the next cycle
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list engine check failed");

`endif

/* rtl/ple_pkg.sv */
// Shared types, codes and sizes of the positional list engine
`timescale 1ns / 1ps
package ple_pkg;

   localparam int CAPACITY   = 64;
   localparam int VALUE_BITS = 8;
   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int LEN_BITS   = $clog2(CAPACITY + 1);

   // Command codes
   localparam logic [3:0] CMD_INS_HEAD = 4'd0;
   localparam logic [3:0] CMD_INS_TAIL = 4'd1;
   localparam logic [3:0] CMD_INS_AT   = 4'd2;
   localparam logic [3:0] CMD_DEL_HEAD = 4'd3;
   localparam logic [3:0] CMD_DEL_TAIL = 4'd4;
   localparam logic [3:0] CMD_DEL_AT   = 4'd5;
   localparam logic [3:0] CMD_UPD_AT   = 4'd6;
   localparam logic [3:0] CMD_FIND     = 4'd7;
   localparam logic [3:0] CMD_REPLACE  = 4'd8;
   localparam logic [3:0] CMD_REVERSE  = 4'd9;
   localparam logic [3:0] CMD_SORT     = 4'd10;
   localparam logic [3:0] CMD_READ     = 4'd11;

   // Status codes
   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_BADPOS   = 3'd1;
   localparam logic [2:0] STS_EMPTY    = 3'd2;
   localparam logic [2:0] STS_FULL     = 3'd3;
   localparam logic [2:0] STS_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [3:0]            command;
      logic [6:0]            position;
      logic [VALUE_BITS-1:0] item_value;
      logic [VALUE_BITS-1:0] replacement_value;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [VALUE_BITS-1:0] read_value;
      logic [6:0]            found_position;
      logic [LEN_BITS-1:0]   length;
   } rsp_type;

   typedef struct packed {
      logic                  we;
      logic [ADDR_BITS-1:0]  waddr;
      logic [VALUE_BITS-1:0] wdata;
      logic [ADDR_BITS-1:0]  raddr;
   } mem_req_type;

endpackage

/* rtl/ple_mem.sv */
// Entry store: one write port, one read port with registered read data
`timescale 1ns / 1ps
module ple_mem (
   input  logic                               clock,
   input  ple_pkg::mem_req_type               mem_req,
   output logic [ple_pkg::VALUE_BITS-1:0]     mem_rdata
);

   logic [ple_pkg::VALUE_BITS-1:0] store_ff [ple_pkg::CAPACITY];
   logic [ple_pkg::VALUE_BITS-1:0] rdata_ff;

   // Write and read the entries
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= store_ff[mem_req.raddr];
   end

   assign mem_rdata = rdata_ff;

endmodule

/* rtl/ple_seq.sv */
// Command sequencer: walks the entry store one access at a time
`timescale 1ns / 1ps
module ple_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ple_pkg::req_type               req_data,
   input  logic                           slot_free,
   output logic                           done,
   output ple_pkg::rsp_type               result,
   output ple_pkg::mem_req_type           mem_req,
   input  logic [ple_pkg::VALUE_BITS-1:0] mem_rdata
);

   localparam int LB = ple_pkg::LEN_BITS;
   localparam int VB = ple_pkg::VALUE_BITS;
   localparam int AB = ple_pkg::ADDR_BITS;
   localparam logic [LB-1:0] CAP = LB'(ple_pkg::CAPACITY);
   localparam logic [LB-1:0] ONE = LB'(1);
   localparam logic [LB-1:0] TWO = LB'(2);

   typedef enum logic [4:0] {
      S_IDLE, S_INS_CHK, S_INS_WR, S_DEL_CHK, S_DEL_WR, S_UPD, S_RD_ISSUE, S_RD_GET,
      S_FIND_RD, S_FIND_CHK, S_REV_RA, S_REV_RB, S_REV_WA, S_REV_WB,
      S_SRT_RI, S_SRT_RJ, S_SRT_CMP, S_SRT_WI, S_SRT_WM, S_DONE
   } state_type;

   state_type       state_ff, state_in;
   logic [3:0]      cmd_ff, cmd_in;
   logic [VB-1:0]   val_ff, val_in;
   logic [VB-1:0]   rep_ff, rep_in;
   logic [LB-1:0]   idx_ff, idx_in;
   logic [LB-1:0]   ptr_ff, ptr_in;
   logic [LB-1:0]   jp_ff, jp_in;
   logic [LB-1:0]   midx_ff, midx_in;
   logic [VB-1:0]   hold_ff, hold_in;
   logic [VB-1:0]   min_ff, min_in;
   logic [LB-1:0]   count_ff, count_in;
   logic [2:0]      status_ff, status_in;
   logic [VB-1:0]   rd_ff, rd_in;
   logic [6:0]      fp_ff, fp_in;
   logic [LB:0]     pos_wide;
   logic [LB:0]     cnt_wide;

   assign pos_wide = (LB+1)'(req_data.position);
   assign cnt_wide = {1'b0, count_ff};

   // Decode commands and step through the store
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      val_in    = val_ff;
      rep_in    = rep_ff;
      idx_in    = idx_ff;
      ptr_in    = ptr_ff;
      jp_in     = jp_ff;
      midx_in   = midx_ff;
      hold_in   = hold_ff;
      min_in    = min_ff;
      count_in  = count_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      fp_in     = fp_ff;
      mem_req   = '0;
      done      = 1'b0;
      req_ready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.command;
               val_in    = req_data.item_value;
               rep_in    = req_data.replacement_value;
               status_in = ple_pkg::STS_OK;
               rd_in     = '0;
               fp_in     = '0;
               ptr_in    = '0;
               state_in  = S_DONE;
               case (req_data.command)
                  ple_pkg::CMD_INS_HEAD, ple_pkg::CMD_INS_TAIL, ple_pkg::CMD_INS_AT: begin
                     ptr_in = count_ff;
                     if (count_ff == CAP) begin
                        status_in = ple_pkg::STS_FULL;
                     end else if (req_data.command == ple_pkg::CMD_INS_HEAD) begin
                        idx_in   = '0;
                        state_in = S_INS_CHK;
                     end else if (req_data.command == ple_pkg::CMD_INS_TAIL) begin
                        idx_in   = count_ff;
                        state_in = S_INS_CHK;
                     end else if (pos_wide == '0 || pos_wide > cnt_wide + 1'b1) begin
                        status_in = ple_pkg::STS_BADPOS;
                     end else begin
                        idx_in   = LB'(pos_wide - 1'b1);
                        state_in = S_INS_CHK;
                     end
                  end
                  ple_pkg::CMD_DEL_HEAD, ple_pkg::CMD_DEL_TAIL: begin
                     if (count_ff == '0) begin
                        status_in = ple_pkg::STS_EMPTY;
                     end else begin
                        ptr_in   = (req_data.command == ple_pkg::CMD_DEL_HEAD) ?
                                   '0 : count_ff - ONE;
                        state_in = S_DEL_CHK;
                     end
                  end
                  ple_pkg::CMD_DEL_AT, ple_pkg::CMD_UPD_AT, ple_pkg::CMD_READ: begin
                     if (count_ff == '0) begin
                        status_in = ple_pkg::STS_EMPTY;
                     end else if (pos_wide == '0 || pos_wide > cnt_wide) begin
                        status_in = ple_pkg::STS_BADPOS;
                     end else begin
                        ptr_in = LB'(pos_wide - 1'b1);
                        if (req_data.command == ple_pkg::CMD_DEL_AT) begin
                           state_in = S_DEL_CHK;
                        end else if (req_data.command == ple_pkg::CMD_UPD_AT) begin
                           state_in = S_UPD;
                        end else begin
                           state_in = S_RD_ISSUE;
                        end
                     end
                  end
                  ple_pkg::CMD_FIND, ple_pkg::CMD_REPLACE: begin
                     if (count_ff == '0) begin
                        status_in = ple_pkg::STS_EMPTY;
                     end else begin
                        state_in = S_FIND_RD;
                     end
                  end
                  ple_pkg::CMD_REVERSE: begin
                     if (count_ff >= TWO) begin
                        jp_in    = count_ff - ONE;
                        state_in = S_REV_RA;
                     end
                  end
                  ple_pkg::CMD_SORT: begin
                     if (count_ff >= TWO) begin
                        state_in = S_SRT_RI;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // Shift entries up by one, then place the new value
         S_INS_CHK: begin
            if (ptr_ff > idx_ff) begin
               mem_req.raddr = AB'(ptr_ff - ONE);
               state_in      = S_INS_WR;
            end else begin
               mem_req.we    = 1'b1;
               mem_req.waddr = AB'(idx_ff);
               mem_req.wdata = val_ff;
               count_in      = count_ff + ONE;
               state_in      = S_DONE;
            end
         end
         S_INS_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = AB'(ptr_ff);
            mem_req.wdata = mem_rdata;
            ptr_in        = ptr_ff - ONE;
            state_in      = S_INS_CHK;
         end
         // Shift later entries down by one
         S_DEL_CHK: begin
            if (ptr_ff + ONE < count_ff) begin
               mem_req.raddr = AB'(ptr_ff + ONE);
               state_in      = S_DEL_WR;
            end else begin
               count_in = count_ff - ONE;
               state_in = S_DONE;
            end
         end
         S_DEL_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = AB'(ptr_ff);
            mem_req.wdata = mem_rdata;
            ptr_in        = ptr_ff + ONE;
            state_in      = S_DEL_CHK;
         end
         S_UPD: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = AB'(ptr_ff);
            mem_req.wdata = val_ff;
            state_in      = S_DONE;
         end
         S_RD_ISSUE: begin
            mem_req.raddr = AB'(ptr_ff);
            state_in      = S_RD_GET;
         end
         S_RD_GET: begin
            rd_in    = mem_rdata;
            state_in = S_DONE;
         end
         // Scan for the first match; replace also overwrites it
         S_FIND_RD: begin
            mem_req.raddr = AB'(ptr_ff);
            state_in      = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            if (mem_rdata == val_ff) begin
               fp_in = 7'(ptr_ff + ONE);
               if (cmd_ff == ple_pkg::CMD_REPLACE) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = AB'(ptr_ff);
                  mem_req.wdata = rep_ff;
               end
               state_in = S_DONE;
            end else if (ptr_ff + ONE == count_ff) begin
               status_in = ple_pkg::STS_NOTFOUND;
               state_in  = S_DONE;
            end else begin
               ptr_in   = ptr_ff + ONE;
               state_in = S_FIND_RD;
            end
         end
         // Swap the outer pair and move inward
         S_REV_RA: begin
            mem_req.raddr = AB'(ptr_ff);
            state_in      = S_REV_RB;
         end
         S_REV_RB: begin
            mem_req.raddr = AB'(jp_ff);
            hold_in       = mem_rdata;
            state_in      = S_REV_WA;
         end
         S_REV_WA: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = AB'(ptr_ff);
            mem_req.wdata = mem_rdata;
            state_in      = S_REV_WB;
         end
         S_REV_WB: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = AB'(jp_ff);
            mem_req.wdata = hold_ff;
            ptr_in        = ptr_ff + ONE;
            jp_in         = jp_ff - ONE;
            state_in      = (ptr_ff + TWO < jp_ff) ? S_REV_RA : S_DONE;
         end
         // Selection sort: find the minimum of the tail, swap it forward
         S_SRT_RI: begin
            mem_req.raddr = AB'(ptr_ff);
            jp_in         = ptr_ff + ONE;
            state_in      = S_SRT_RJ;
         end
         S_SRT_RJ: begin
            mem_req.raddr = AB'(jp_ff);
            hold_in       = mem_rdata;
            min_in        = mem_rdata;
            midx_in       = ptr_ff;
            state_in      = S_SRT_CMP;
         end
         S_SRT_CMP: begin
            if (min_ff > mem_rdata) begin
               min_in  = mem_rdata;
               midx_in = jp_ff;
            end
            if (jp_ff + ONE < count_ff) begin
               mem_req.raddr = AB'(jp_ff + ONE);
               jp_in         = jp_ff + ONE;
            end else begin
               state_in = S_SRT_WI;
            end
         end
         S_SRT_WI: begin
            if (midx_ff != ptr_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = AB'(ptr_ff);
               mem_req.wdata = min_ff;
               state_in      = S_SRT_WM;
            end else begin
               ptr_in   = ptr_ff + ONE;
               state_in = (ptr_ff + TWO < count_ff) ? S_SRT_RI : S_DONE;
            end
         end
         S_SRT_WM: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = AB'(midx_ff);
            mem_req.wdata = hold_ff;
            ptr_in        = ptr_ff + ONE;
            state_in      = (ptr_ff + TWO < count_ff) ? S_SRT_RI : S_DONE;
         end
         // Hand the result over once the output slot is free
         S_DONE: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result.status         = status_ff;
   assign result.read_value     = rd_ff;
   assign result.found_position = fp_ff;
   assign result.length         = count_ff;

   // Hold state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cmd_ff    <= cmd_in;
      val_ff    <= val_in;
      rep_ff    <= rep_in;
      idx_ff    <= idx_in;
      ptr_ff    <= ptr_in;
      jp_ff     <= jp_in;
      midx_ff   <= midx_in;
      hold_ff   <= hold_in;
      min_ff    <= min_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
      fp_ff     <= fp_in;
   end

endmodule

/* rtl/positional_list_engine.sv */
// Top level of the positional list engine: sequencer, entry store, output register
//
// A bounded ordered list of up to 64 byte values, one command per request.
// Request channel req_valid/req_ready/req_data carries command, position,
// item value and replacement value; each request returns exactly one result
// on rsp_valid/rsp_ready/rsp_data: status, read value, found position, length.
// All entries sit in one single-port-write memory with registered read data;
// the sequencer touches one entry per access, so find/replace, insert/delete,
// reverse and sort take longer the more entries they scan, move or swap.
// The result is latched in an output register; the next request is taken
// while that result waits, and a stalled receiver only holds back the
// following result. Reset empties the list (length zero) at once.
`timescale 1ns / 1ps
`include "positional_list_engine_macros.svh"
module positional_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ple_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ple_pkg::rsp_type rsp_data
);

   ple_pkg::mem_req_type           mem_req;
   logic [ple_pkg::VALUE_BITS-1:0] mem_rdata;
   ple_pkg::rsp_type               result;
   logic                           done;
   logic                           slot_free;
   logic                           rsp_valid_ff, rsp_valid_in;
   ple_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   ple_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .slot_free (slot_free),
      .done      (done),
      .result    (result),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   ple_mem u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   // Load a new result when the slot is empty or being drained
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = done ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = done ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PLE_ASSERT_NOW(a_len_bound, clock, reset, rsp_valid, rsp_data.length <= 7'(ple_pkg::CAPACITY))
   `PLE_ASSERT_NOW(a_full_len, clock, reset, rsp_valid && rsp_data.status == ple_pkg::STS_FULL, rsp_data.length == 7'(ple_pkg::CAPACITY))
   `PLE_ASSERT_NOW(a_nf_pos, clock, reset, rsp_valid && rsp_data.status == ple_pkg::STS_NOTFOUND, rsp_data.found_position == 7'd0)
   `PLE_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)

endmodule

/* dv/positional_list_engine_test.sv */
// Self-checking testbench for the positional list engine: directed table, fill to capacity, then random commands
`timescale 1ns / 1ps
module positional_list_engine_test;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ple_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ple_pkg::rsp_type rsp_data;

   positional_list_engine u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // Mirror of the list contents and the expected responses
   logic [ple_pkg::VALUE_BITS-1:0] list_mem [ple_pkg::CAPACITY];
   int unsigned                    list_len;
   ple_pkg::rsp_type               pending_rsp [$];
   int                             fail_count = 0;
   bit                             quiet = 1'b0;
   bit                             done = 1'b0;

   function automatic ple_pkg::rsp_type apply_command(ple_pkg::req_type r);
      ple_pkg::rsp_type               o;
      int unsigned                    p, i, j, m, k;
      logic [ple_pkg::VALUE_BITS-1:0] t;
      o = '0;
      p = r.position;
      case (r.command)
         ple_pkg::CMD_INS_HEAD, ple_pkg::CMD_INS_TAIL, ple_pkg::CMD_INS_AT: begin
            k = (r.command == ple_pkg::CMD_INS_HEAD) ? 1 :
                (r.command == ple_pkg::CMD_INS_TAIL) ? list_len + 1 : p;
            if (list_len >= ple_pkg::CAPACITY) o.status = ple_pkg::STS_FULL;
            else if (k < 1 || k > list_len + 1) o.status = ple_pkg::STS_BADPOS;
            else begin
               for (i = list_len; i > k - 1; i--) list_mem[i] = list_mem[i-1];
               list_mem[k-1] = r.item_value;
               list_len++;
            end
         end
         ple_pkg::CMD_DEL_HEAD, ple_pkg::CMD_DEL_TAIL: begin
            if (list_len == 0) o.status = ple_pkg::STS_EMPTY;
            else begin
               k = (r.command == ple_pkg::CMD_DEL_HEAD) ? 0 : list_len - 1;
               for (i = k; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         ple_pkg::CMD_DEL_AT, ple_pkg::CMD_UPD_AT, ple_pkg::CMD_READ: begin
            if (list_len == 0) o.status = ple_pkg::STS_EMPTY;
            else if (p < 1 || p > list_len) o.status = ple_pkg::STS_BADPOS;
            else if (r.command == ple_pkg::CMD_DEL_AT) begin
               for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end else if (r.command == ple_pkg::CMD_UPD_AT) list_mem[p-1] = r.item_value;
            else o.read_value = list_mem[p-1];
         end
         ple_pkg::CMD_FIND, ple_pkg::CMD_REPLACE: begin
            if (list_len == 0) o.status = ple_pkg::STS_EMPTY;
            else begin
               k = list_len;
               for (i = 0; i < list_len; i++)
                  if (k == list_len && list_mem[i] == r.item_value) k = i;
               if (k == list_len) o.status = ple_pkg::STS_NOTFOUND;
               else begin
                  o.found_position = 7'(k + 1);
                  if (r.command == ple_pkg::CMD_REPLACE) list_mem[k] = r.replacement_value;
               end
            end
         end
         ple_pkg::CMD_REVERSE: begin
            for (i = 0; i < list_len / 2; i++) begin
               j = list_len - 1 - i;
               t = list_mem[i]; list_mem[i] = list_mem[j]; list_mem[j] = t;
            end
         end
         ple_pkg::CMD_SORT: begin
            for (i = 0; i + 1 < list_len; i++) begin
               m = i;
               for (j = i + 1; j < list_len; j++) if (list_mem[m] > list_mem[j]) m = j;
               t = list_mem[i]; list_mem[i] = list_mem[m]; list_mem[m] = t;
            end
         end
         default: ;
      endcase
      o.length = ple_pkg::LEN_BITS'(list_len);
      return o;
   endfunction

   // Directed table: command, position, value, replacement, typed response, whether typed
   typedef struct {
      ple_pkg::req_type r;
      ple_pkg::rsp_type x;
      bit               typed;
   } row_type;
   row_type dir_rows [$];

   function automatic ple_pkg::req_type mk(logic [3:0] c, logic [6:0] p, logic [7:0] v,
                                           logic [7:0] w);
      ple_pkg::req_type r;
      r.command = c; r.position = p; r.item_value = v; r.replacement_value = w;
      return r;
   endfunction

   function automatic ple_pkg::rsp_type rs(logic [2:0] s, logic [7:0] rv, logic [6:0] fp,
                                           int len);
      ple_pkg::rsp_type o;
      o.status = s; o.read_value = rv; o.found_position = fp;
      o.length = ple_pkg::LEN_BITS'(len);
      return o;
   endfunction

   task automatic add_row(ple_pkg::req_type r, ple_pkg::rsp_type x, bit typed);
      row_type w;
      w.r = r; w.x = x; w.typed = typed;
      dir_rows.push_back(w);
   endtask

   function automatic ple_pkg::req_type rand_request();
      ple_pkg::req_type r;
      int               sel;
      sel = $urandom_range(0, 99);
      r.position          = 7'($urandom);
      r.item_value        = 8'($urandom);
      r.replacement_value = 8'($urandom);
      if (sel < 40)
         r.command = 4'($urandom_range(ple_pkg::CMD_INS_HEAD, ple_pkg::CMD_INS_AT));
      else if (sel < 95)
         r.command = 4'($urandom_range(ple_pkg::CMD_DEL_HEAD, ple_pkg::CMD_READ));
      else r.command = 4'($urandom_range(12, 15));
      // Keep positions mostly legal, sometimes off by one or out of range
      if ($urandom_range(0, 9) < 8) r.position = 7'($urandom_range(0, list_len + 1));
      // Look for stored values often so find and replace hit
      if (list_len > 0 && $urandom_range(0, 1))
         r.item_value = list_mem[$urandom_range(0, list_len - 1)];
      return r;
   endfunction

   // Random idling, with a calm window in the middle of the run
   function automatic bit idle_now();
      return !quiet && ($urandom_range(0, 99) < 13);
   endfunction

   // Send one request and hold it until taken
   task automatic send_request(ple_pkg::req_type r, ple_pkg::rsp_type x, bit typed);
      ple_pkg::rsp_type p;
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = apply_command(r);
      pending_rsp.push_back(typed ? x : p);
   endtask

   // Drain and check responses
   always @(posedge clock) begin
      ple_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t unexpected response: expected none, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t status: expected %0d actual %0d", $time, want.status,
                           rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.read_value !== want.read_value) begin
                  $display("%0t read_value: expected %0d actual %0d", $time, want.read_value,
                           rsp_data.read_value);
                  fail_count++;
               end
               if (rsp_data.found_position !== want.found_position) begin
                  $display("%0t found_position: expected %0d actual %0d", $time,
                           want.found_position, rsp_data.found_position);
                  fail_count++;
               end
               if (rsp_data.length !== want.length) begin
                  $display("%0t length: expected %0d actual %0d", $time, want.length,
                           rsp_data.length);
                  fail_count++;
               end
            end
         end
         rsp_ready <= !idle_now();
      end
   end

   initial begin
      int n;
      for (n = 0; n < ple_pkg::CAPACITY; n++) list_mem[n] = '0;
      list_len = 0;
      // Empty list cases, then extremes and every command
      add_row(mk(ple_pkg::CMD_DEL_HEAD, 0, 0, 0), rs(ple_pkg::STS_EMPTY, 0, 0, 0), 1);
      add_row(mk(ple_pkg::CMD_DEL_TAIL, 0, 0, 0), rs(ple_pkg::STS_EMPTY, 0, 0, 0), 1);
      add_row(mk(ple_pkg::CMD_DEL_AT, 1, 0, 0), rs(ple_pkg::STS_EMPTY, 0, 0, 0), 1);
      add_row(mk(ple_pkg::CMD_UPD_AT, 1, 0, 0), rs(ple_pkg::STS_EMPTY, 0, 0, 0), 1);
      add_row(mk(ple_pkg::CMD_READ, 1, 0, 0), rs(ple_pkg::STS_EMPTY, 0, 0, 0), 1);
      add_row(mk(ple_pkg::CMD_FIND, 0, 8'hff, 0), rs(ple_pkg::STS_EMPTY, 0, 0, 0), 1);
      add_row(mk(ple_pkg::CMD_REPLACE, 0, 8'hff, 1), rs(ple_pkg::STS_EMPTY, 0, 0, 0), 1);
      add_row(mk(ple_pkg::CMD_REVERSE, 0, 0, 0), rs(ple_pkg::STS_OK, 0, 0, 0), 1);
      add_row(mk(ple_pkg::CMD_SORT, 0, 0, 0), rs(ple_pkg::STS_OK, 0, 0, 0), 1);
      add_row(mk(ple_pkg::CMD_INS_AT, 0, 5, 0), rs(ple_pkg::STS_BADPOS, 0, 0, 0), 1);
      add_row(mk(ple_pkg::CMD_INS_AT, 1, 8'hff, 0), rs(ple_pkg::STS_OK, 0, 0, 1), 1);
      add_row(mk(ple_pkg::CMD_INS_HEAD, 0, 8'h00, 0), rs(ple_pkg::STS_OK, 0, 0, 2), 1);
      add_row(mk(ple_pkg::CMD_INS_TAIL, 7'h7f, 8'h80, 8'hff), rs(ple_pkg::STS_OK, 0, 0, 3), 1);
      add_row(mk(ple_pkg::CMD_INS_AT, 7'h7f, 1, 0), rs(ple_pkg::STS_BADPOS, 0, 0, 3), 1);
      add_row(mk(ple_pkg::CMD_READ, 3, 0, 0), rs(ple_pkg::STS_OK, 8'h80, 0, 3), 1);
      add_row(mk(ple_pkg::CMD_READ, 4, 0, 0), rs(ple_pkg::STS_BADPOS, 0, 0, 3), 1);
      add_row(mk(ple_pkg::CMD_FIND, 0, 8'h7f, 0), rs(ple_pkg::STS_NOTFOUND, 0, 0, 3), 1);
      add_row(mk(ple_pkg::CMD_REPLACE, 0, 8'hff, 8'h55), rs(ple_pkg::STS_OK, 0, 2, 3), 1);
      add_row(mk(ple_pkg::CMD_UPD_AT, 1, 8'haa, 0), rs(ple_pkg::STS_OK, 0, 0, 3), 1);
      add_row(mk(ple_pkg::CMD_REVERSE, 0, 0, 0), '0, 0);
      add_row(mk(ple_pkg::CMD_SORT, 0, 0, 0), '0, 0);
      add_row(mk(ple_pkg::CMD_DEL_AT, 2, 0, 0), '0, 0);
      add_row(mk(4'd15, 7'h7f, 8'hff, 8'hff), rs(ple_pkg::STS_OK, 0, 0, 2), 1);
      add_row(mk(ple_pkg::CMD_DEL_TAIL, 0, 0, 0), '0, 0);
      add_row(mk(ple_pkg::CMD_DEL_HEAD, 0, 0, 0), rs(ple_pkg::STS_OK, 0, 0, 0), 1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_request(dir_rows[i].r, dir_rows[i].x, dir_rows[i].typed);
      // Fill to capacity and try one more
      for (n = 0; n < ple_pkg::CAPACITY; n++)
         send_request(mk(ple_pkg::CMD_INS_TAIL, 0, 8'($urandom), 0), '0, 0);
      send_request(mk(ple_pkg::CMD_INS_HEAD, 0, 1, 0),
                   rs(ple_pkg::STS_FULL, 0, 0, ple_pkg::CAPACITY), 1);
      send_request(mk(ple_pkg::CMD_SORT, 0, 0, 0), '0, 0);
      send_request(mk(ple_pkg::CMD_READ, 7'(ple_pkg::CAPACITY), 0, 0), '0, 0);
      send_request(mk(ple_pkg::CMD_REVERSE, 0, 0, 0), '0, 0);
      for (n = 0; n < 410; n++) begin
         quiet = (n >= 150 && n < 260);
         send_request(rand_request(), '0, 0);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("positional_list_engine regression: pass");
      else
         $display("positional_list_engine regression: fail");
      done = 1'b1;
      $finish;
   end

   // Watchdog
   initial begin
      #20ms;
      if (!done) $display("positional_list_engine regression: fail");
      $finish;
   end
endmodule

/* positional_list_engine.f */
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_mem.sv
rtl/ple_seq.sv
rtl/positional_list_engine.sv
dv/positional_list_engine_test.sv
